### hdl/tdb_pkg.sv
// Shared types and constants for the task duty budget state machine.
package tdb_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TASK_ID       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUEUE_PRESENT = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACTIVE_BUDGET = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAUSE_LENGTH  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_ELAPSED   = 3'd4;

   localparam logic [1:0] CMD_SET_GO = 2'd1;
   localparam logic [1:0] CMD_CLR_GO = 2'd2;

   localparam logic signed [7:0] TASK_NONE = -8'sd1;

   typedef enum logic [1:0] {
      SM_INIT   = 2'd0,
      SM_READY  = 2'd1,
      SM_ACTIVE = 2'd2,
      SM_PAUSE  = 2'd3
   } state_type;

   typedef struct packed {
      logic signed [7:0] task_id;
      logic              queue_present;
      logic [31:0]       active_budget;
      logic [31:0]       pause_length;
      logic [31:0]       min_elapsed;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] now_tick;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]        fsm_state;
      logic              enqueue_valid;
      logic signed [7:0] enqueue_id;
      logic [31:0]       active_left;
      logic [31:0]       pause_left;
   } rsp_payload_type;

endpackage

### hdl/task_duty_budget_fsm.sv
// Top level of the per-task run-budget state machine.
//
//   channel   ports                                  direction   beat moves
//   request   req_valid, req_stall, req_payload      in          command, now_tick
//   response  rsp_valid, rsp_stall, rsp_payload      out         state, enqueue, counters
//   config    csr_wr_en, csr_index, csr_wr_data      in          one register write
//
// A request beat lands in an input register and is evaluated from there by
// single-level step logic that writes the state and the response register together.
// Throughput is one beat per clock while the response is not stalled.
// Reset is synchronous; it clears the state machine and loads the register defaults.
// A stalled response holds the step logic, and the input register then stalls requests.
module task_duty_budget_fsm #(
   parameter int TICK_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tdb_pkg::req_payload_type             req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tdb_pkg::rsp_payload_type             rsp_payload,
   input  logic                                 csr_wr_en,
   input  logic [tdb_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [tdb_pkg::CSR_DATA_WIDTH-1:0]   csr_wr_data
);
   import tdb_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_payload_ff;
   logic            in_take;
   logic            req_accept;
   cfg_type         cfg;

   assign req_stall  = in_valid_ff && !in_take;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else begin
         in_valid_in = in_valid_ff && !in_take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_payload_ff <= req_payload;
      end
   end

   tdb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   tdb_core #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (in_valid_ff),
      .in_payload  (in_payload_ff),
      .in_take     (in_take),
      .cfg         (cfg),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

### hdl/tdb_csr.sv
// Configuration register file for the task duty budget state machine.
module tdb_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [tdb_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [tdb_pkg::CSR_DATA_WIDTH-1:0]   csr_wr_data,
   output tdb_pkg::cfg_type                     cfg
);
   import tdb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TASK_ID:       cfg_in.task_id       = csr_wr_data[7:0];
            CSR_QUEUE_PRESENT: cfg_in.queue_present = csr_wr_data[0];
            CSR_ACTIVE_BUDGET: cfg_in.active_budget = csr_wr_data[31:0];
            CSR_PAUSE_LENGTH:  cfg_in.pause_length  = csr_wr_data[31:0];
            CSR_MIN_ELAPSED:   cfg_in.min_elapsed   = csr_wr_data[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.task_id       <= TASK_NONE;
         cfg_ff.queue_present <= 1'b0;
         cfg_ff.active_budget <= '0;
         cfg_ff.pause_length  <= '0;
         cfg_ff.min_elapsed   <= 32'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/tdb_core.sv
// Step logic, state registers and result register of the budget state machine.
module tdb_core #(
   parameter int TICK_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  tdb_pkg::req_payload_type in_payload,
   output logic                     in_take,
   input  tdb_pkg::cfg_type         cfg,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tdb_pkg::rsp_payload_type rsp_payload
);
   import tdb_pkg::*;

   localparam int CALC_WIDTH = (TICK_WIDTH > 32) ? TICK_WIDTH : 32;

   state_type             state_ff, state_in;
   logic                  entry_ff, entry_in;
   logic                  go_ff, go_in;
   logic [TICK_WIDTH-1:0] last_ff, last_in;
   logic [31:0]           budget_ff, budget_in;
   logic [31:0]           pause_ff, pause_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   logic                  go_eff;
   logic                  enq;
   logic [CALC_WIDTH-1:0] now_ext;
   logic [TICK_WIDTH-1:0] tick;
   logic [TICK_WIDTH-1:0] last_base;
   logic [TICK_WIDTH-1:0] diff;
   logic [CALC_WIDTH-1:0] diff_ext;
   logic [CALC_WIDTH-1:0] oper_ext;
   logic [CALC_WIDTH-1:0] sat_full;
   logic [31:0]           sub_oper;
   logic [31:0]           sub_result;
   logic                  charge;

   // A new step runs whenever the result register is empty or being drained.
   assign in_take = in_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      unique case (in_payload.command)
         CMD_SET_GO: go_eff = 1'b1;
         CMD_CLR_GO: go_eff = 1'b0;
         default:    go_eff = go_ff;
      endcase
   end

   // One shared saturating subtractor serves both the active and pause counters.
   // On an entry step the elapsed time is zero because the base is the tick itself.
   assign now_ext    = CALC_WIDTH'(in_payload.now_tick);
   assign tick       = now_ext[TICK_WIDTH-1:0];
   assign last_base  = entry_ff ? tick : last_ff;
   assign diff       = tick - last_base;
   assign diff_ext   = CALC_WIDTH'(diff);
   assign charge     = diff_ext >= CALC_WIDTH'(cfg.min_elapsed);
   assign sub_oper   = (state_ff == SM_ACTIVE) ? budget_ff
                     : (entry_ff ? cfg.pause_length : pause_ff);
   assign oper_ext   = CALC_WIDTH'(sub_oper);
   assign sat_full   = (oper_ext > diff_ext) ? (oper_ext - diff_ext) : '0;
   assign sub_result = sat_full[31:0];

   always_comb begin
      state_in  = state_ff;
      entry_in  = entry_ff;
      go_in     = go_eff;
      last_in   = last_ff;
      budget_in = budget_ff;
      pause_in  = pause_ff;
      enq       = 1'b0;
      unique case (state_ff)
         SM_INIT: begin
            if (entry_ff) begin
               if ((cfg.task_id == TASK_NONE) || !cfg.queue_present) begin
                  entry_in = 1'b1;
               end else begin
                  budget_in = cfg.active_budget;
                  state_in  = SM_READY;
                  entry_in  = 1'b1;
               end
            end
         end
         SM_READY: begin
            if (entry_ff) begin
               enq      = cfg.queue_present;
               go_in    = 1'b0;
               entry_in = 1'b0;
            end
            if (go_in) begin
               state_in = SM_ACTIVE;
               entry_in = 1'b1;
            end
         end
         SM_ACTIVE: begin
            entry_in = 1'b0;
            last_in  = last_base;
            if (charge) begin
               budget_in = sub_result;
               last_in   = tick;
               // Pause takes priority over a cleared go flag.
               if (sub_result == 32'd0) begin
                  state_in = SM_PAUSE;
                  entry_in = 1'b1;
               end else if (!go_eff) begin
                  state_in = SM_READY;
                  entry_in = 1'b1;
               end
            end
         end
         SM_PAUSE: begin
            entry_in = 1'b0;
            last_in  = last_base;
            pause_in = sub_oper;
            if (entry_ff) begin
               budget_in = cfg.active_budget;
            end
            if (charge) begin
               pause_in = sub_result;
               last_in  = tick;
               if (sub_result == 32'd0) begin
                  state_in = SM_READY;
                  entry_in = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_payload_in.fsm_state     = state_in;
      rsp_payload_in.enqueue_valid = enq;
      rsp_payload_in.enqueue_id    = enq ? cfg.task_id : 8'sd0;
      rsp_payload_in.active_left   = budget_in;
      rsp_payload_in.pause_left    = pause_in;
   end

   always_comb begin
      if (in_take) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SM_INIT;
         entry_ff     <= 1'b1;
         go_ff        <= 1'b0;
         last_ff      <= '0;
         budget_ff    <= '0;
         pause_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_take) begin
            state_ff  <= state_in;
            entry_ff  <= entry_in;
            go_ff     <= go_in;
            last_ff   <= last_in;
            budget_ff <= budget_in;
            pause_ff  <= pause_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_enq_in_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.enqueue_valid |-> rsp_payload_ff.fsm_state == SM_READY)
      else $error("enqueue request reported outside the ready state");

   a_rsp_tracks_state: assert property (@(posedge clock) disable iff (reset)
      in_take |=> rsp_valid_ff && (rsp_payload_ff.fsm_state == state_ff))
      else $error("result beat does not match the committed state");

   a_init_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == SM_INIT |-> entry_ff)
      else $error("init state lost its pending entry action");

   a_go_cleared_on_ready_entry: assert property (@(posedge clock) disable iff (reset)
      in_take && (state_ff == SM_READY) && entry_ff |=> !go_ff && (state_ff == SM_READY))
      else $error("ready entry did not clear the go flag");

endmodule

### tb/tb_task_duty_budget_fsm.sv
// Self-checking testbench for the task duty budget state machine.
module tb_task_duty_budget_fsm;
   timeunit 1ns;
   timeprecision 1ps;

   import tdb_pkg::*;

   localparam logic [1:0] CMD_STEP     = 2'd0;
   localparam logic [1:0] CMD_RESERVED = 2'd3;
   localparam int RSP_LATENCY = 2;
   localparam int IDLE_PCT    = 15;
   localparam int HOLD_CYCLES = 60;
   localparam int STALL_LIMIT = 2000;
   localparam int CSR_SLOTS   = 2 ** CSR_INDEX_WIDTH;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   req_payload_type            req_payload;
   logic                       rsp_valid;
   logic                       rsp_stall;
   rsp_payload_type            rsp_payload;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wr_data;

   // Mirror of the block's registers and state machine.
   cfg_type     cfg_now;
   state_type   fsm_now;
   logic        entry_due;
   logic        go_now;
   logic [31:0] last_tick;
   logic [31:0] budget_now;
   logic [31:0] pause_now;

   rsp_payload_type due_results[$];
   int          mismatch_count;
   int          req_idle_pct;
   int          rsp_idle_pct;
   int          hold_left;
   int          quiet_cycles;
   logic [31:0] tick_now;

   task_duty_budget_fsm i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // One evaluation step: command first, then the current state runs.
   function automatic rsp_payload_type step_budget_fsm(input logic [1:0] cmd,
                                                       input logic [31:0] tick);
      rsp_payload_type r;
      logic [31:0]     elapsed;
      logic            entry;
      logic            enq;
      enq = 1'b0;
      if (cmd == CMD_SET_GO) begin
         go_now = 1'b1;
      end else if (cmd == CMD_CLR_GO) begin
         go_now = 1'b0;
      end
      entry     = entry_due;
      entry_due = 1'b0;
      case (fsm_now)
         SM_INIT: begin
            if (entry) begin
               if (cfg_now.task_id == TASK_NONE || !cfg_now.queue_present) begin
                  entry_due = 1'b1;
               end else begin
                  budget_now = cfg_now.active_budget;
                  fsm_now    = SM_READY;
                  entry_due  = 1'b1;
               end
            end
         end
         SM_READY: begin
            if (entry) begin
               enq    = cfg_now.queue_present;
               go_now = 1'b0;
            end
            if (go_now) begin
               fsm_now   = SM_ACTIVE;
               entry_due = 1'b1;
            end
         end
         SM_ACTIVE: begin
            if (entry) last_tick = tick;
            elapsed = tick - last_tick;
            if (elapsed >= cfg_now.min_elapsed) begin
               budget_now = (budget_now > elapsed) ? budget_now - elapsed : 32'd0;
               last_tick  = tick;
               if (!go_now) begin
                  fsm_now   = SM_READY;
                  entry_due = 1'b1;
               end
               // An exhausted budget overrides the return to ready.
               if (budget_now == 32'd0) begin
                  fsm_now   = SM_PAUSE;
                  entry_due = 1'b1;
               end
            end
         end
         SM_PAUSE: begin
            if (entry) begin
               budget_now = cfg_now.active_budget;
               pause_now  = cfg_now.pause_length;
               last_tick  = tick;
            end
            elapsed = tick - last_tick;
            if (elapsed >= cfg_now.min_elapsed) begin
               pause_now = (pause_now > elapsed) ? pause_now - elapsed : 32'd0;
               last_tick = tick;
               if (pause_now == 32'd0) begin
                  fsm_now   = SM_READY;
                  entry_due = 1'b1;
               end
            end
         end
      endcase
      r.fsm_state     = fsm_now;
      r.enqueue_valid = enq;
      r.enqueue_id    = enq ? cfg_now.task_id : 8'sd0;
      r.active_left   = budget_now;
      r.pause_left    = pause_now;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic logic [31:0] random_span();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(0, 30);
      if (r < 85) return $urandom_range(31, 1000);
      if (r < 92) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   task automatic send_beat(input logic [1:0] cmd, input logic [31:0] tick);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid            = 1'b1;
      req_payload.command  = cmd;
      req_payload.now_tick = tick;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      due_results.push_back(step_budget_fsm(cmd, tick));
   endtask

   // Lets the block run dry so that registers can be written safely.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_TASK_ID:       cfg_now.task_id       = data[7:0];
         CSR_QUEUE_PRESENT: cfg_now.queue_present = data[0];
         CSR_ACTIVE_BUDGET: cfg_now.active_budget = data;
         CSR_PAUSE_LENGTH:  cfg_now.pause_length  = data;
         CSR_MIN_ELAPSED:   cfg_now.min_elapsed   = data;
         default: ;
      endcase
   endtask

   task automatic load_random_config();
      int r;
      r = $urandom_range(99);
      csr_write(CSR_TASK_ID, (r < 80) ? $urandom_range(0, 127)
                           : (r < 90) ? 32'(TASK_NONE) : $urandom);
      csr_write(CSR_QUEUE_PRESENT, 32'($urandom_range(99) < 85));
      csr_write(CSR_ACTIVE_BUDGET, random_span());
      csr_write(CSR_PAUSE_LENGTH, random_span());
      r = $urandom_range(99);
      csr_write(CSR_MIN_ELAPSED, (r < 60) ? $urandom_range(1, 4)
                               : (r < 72) ? 32'd0
                               : (r < 88) ? $urandom_range(5, 40)
                               : (r < 94) ? 32'hFFFF_FFFF : $urandom);
   endtask

   // Mostly small forward tick steps so the counters run out, with rare jumps.
   task automatic send_random_beats(input int count);
      int          r;
      logic [1:0]  cmd;
      for (int i = 0; i < count; i++) begin
         r   = $urandom_range(99);
         cmd = (r < 22) ? CMD_SET_GO : (r < 32) ? CMD_CLR_GO
             : (r < 36) ? CMD_RESERVED : CMD_STEP;
         r = $urandom_range(99);
         if (r < 70) tick_now += $urandom_range(0, 4);
         else if (r < 90) tick_now += $urandom_range(5, 60);
         else if (r < 95) tick_now += $urandom;
         else tick_now = $urandom;
         send_beat(cmd, tick_now);
      end
   endtask

   task automatic test_init_hold();
      send_beat(CMD_STEP, 32'd0);
      send_beat(CMD_RESERVED, 32'hFFFF_FFFF);
      settle();
      csr_write(CSR_TASK_ID, 32'd127);
      send_beat(CMD_SET_GO, 32'd1);
   endtask

   task automatic test_duty_cycle();
      settle();
      csr_write(CSR_QUEUE_PRESENT, 32'd1);
      csr_write(CSR_ACTIVE_BUDGET, 32'd10);
      csr_write(CSR_PAUSE_LENGTH, 32'd4);
      csr_write(CSR_MIN_ELAPSED, 32'd1);
      send_beat(CMD_STEP, 32'd100);
      send_beat(CMD_SET_GO, 32'd100);
      send_beat(CMD_SET_GO, 32'd101);
      send_beat(CMD_STEP, 32'd102);
      send_beat(CMD_STEP, 32'd105);
      send_beat(CMD_CLR_GO, 32'd107);
      send_beat(CMD_STEP, 32'd107);
      send_beat(CMD_SET_GO, 32'd108);
      send_beat(CMD_STEP, 32'hFFFF_FFF0);
      send_beat(CMD_STEP, 32'd2);
      send_beat(CMD_STEP, 32'd3);
      send_beat(CMD_STEP, 32'd5);
      send_beat(CMD_STEP, 32'd9);
      send_beat(CMD_STEP, 32'd9);
      send_beat(CMD_SET_GO, 32'd10);
      send_beat(CMD_STEP, 32'd11);
      // Budget runs out on the same step that clears go.
      send_beat(CMD_CLR_GO, 32'd30);
   endtask

   task automatic test_extremes();
      settle();
      csr_write(CSR_MIN_ELAPSED, 32'd0);
      csr_write(CSR_ACTIVE_BUDGET, 32'hFFFF_FFFF);
      csr_write(CSR_PAUSE_LENGTH, 32'd0);
      csr_write(CSR_TASK_ID, 32'(TASK_NONE));
      for (int i = CSR_MIN_ELAPSED + 1; i < CSR_SLOTS; i++) begin
         csr_write(CSR_INDEX_WIDTH'(i), $urandom);
      end
      send_beat(CMD_STEP, 32'd40);
      send_beat(CMD_STEP, 32'd40);
      send_beat(CMD_SET_GO, 32'd41);
      send_beat(CMD_STEP, 32'd0);
      send_beat(CMD_STEP, 32'hFFFF_FFFF);
      settle();
      csr_write(CSR_MIN_ELAPSED, 32'hFFFF_FFFF);
      csr_write(CSR_QUEUE_PRESENT, 32'd0);
      csr_write(CSR_PAUSE_LENGTH, 32'hFFFF_FFFF);
      csr_write(CSR_ACTIVE_BUDGET, 32'd5);
      send_beat(CMD_STEP, 32'd0);
      send_beat(CMD_STEP, 32'hFFFF_FFFF);
      send_beat(CMD_SET_GO, 32'd1);
      send_beat(CMD_SET_GO, 32'd2);
      send_beat(CMD_CLR_GO, 32'd3);
   endtask

   task automatic test_random_settings();
      repeat (6) begin
         settle();
         load_random_config();
         send_random_beats($urandom_range(60, 110));
      end
   endtask

   task automatic test_back_pressure();
      settle();
      load_random_config();
      req_idle_pct = 0;
      hold_left    = HOLD_CYCLES;
      send_random_beats(40);
      req_idle_pct = IDLE_PCT;
   endtask

   task automatic test_no_idle();
      settle();
      load_random_config();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_random_beats(150);
      req_idle_pct = IDLE_PCT;
      rsp_idle_pct = IDLE_PCT;
   endtask

   // Result side: random stalls, plus a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $error("response beat with no expectation waiting");
            mismatch_count++;
         end else begin
            want = due_results.pop_front();
            check_field("fsm_state", 32'(want.fsm_state), 32'(rsp_payload.fsm_state));
            check_field("enqueue_valid", 32'(want.enqueue_valid),
                        32'(rsp_payload.enqueue_valid));
            check_field("enqueue_id", 32'(want.enqueue_id), 32'(rsp_payload.enqueue_id));
            check_field("active_left", want.active_left, rsp_payload.active_left);
            check_field("pause_left", want.pause_left, rsp_payload.pause_left);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      rsp_stall      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wr_data    = '0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      hold_left      = 0;
      req_idle_pct   = IDLE_PCT;
      rsp_idle_pct   = IDLE_PCT;
      tick_now       = $urandom;

      cfg_now.task_id       = TASK_NONE;
      cfg_now.queue_present = 1'b0;
      cfg_now.active_budget = 32'd0;
      cfg_now.pause_length  = 32'd0;
      cfg_now.min_elapsed   = 32'd1;
      fsm_now    = SM_INIT;
      entry_due  = 1'b1;
      go_now     = 1'b0;
      last_tick  = 32'd0;
      budget_now = 32'd0;
      pause_now  = 32'd0;

      repeat (2) @(negedge clock);
      reset = 1'b0;

      test_init_hold();
      test_duty_cycle();
      test_extremes();
      test_random_settings();
      test_back_pressure();
      test_no_idle();

      settle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
